// ===== hw/rtl/msub_pkg.sv =====
package msub_pkg;

    localparam int unsigned LenWidth   = 28;
    localparam int unsigned IdWidth    = 16;
    localparam int unsigned CountWidth = 3;
    localparam logic [CountWidth-1:0] MaxLenBytes = 3'd4;
    localparam logic [7:0] Low7Mask = 8'd127;
    localparam logic [7:0] ContBit  = 8'd128;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_ID_HI   = 3'd2,
        PH_ID_LO   = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DRAIN   = 3'd5
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [7:0]            header;
        logic [LenWidth-1:0]   len_acc;
        logic [CountWidth-1:0] len_cnt;
        logic [IdWidth-1:0]    pkt_id;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]          header_byte;
        logic [LenWidth-1:0] remaining_length;
        logic [IdWidth-1:0]  packet_id;
        logic [7:0]          return_code;
        logic                return_code_valid;
        logic                length_error;
        logic                message_end;
    } parse_result_t;

endpackage

// ===== hw/rtl/msub_step.sv =====
module msub_step
    import msub_pkg::*;
(
    input  parse_state_t  state,
    input  logic [7:0]    data_byte,
    input  logic          final_byte,
    output parse_state_t  state_next,
    output parse_result_t result
);

    logic [LenWidth-1:0] len_group;
    logic [7:0]          rc;
    logic                rc_valid;
    logic                err;

    // place the 7-bit group at its varint position
    always_comb
    begin
        len_group = '0;
        case (state.len_cnt)
            3'd0:    len_group = {21'd0, data_byte[6:0]};
            3'd1:    len_group = {14'd0, data_byte[6:0], 7'd0};
            3'd2:    len_group = {7'd0, data_byte[6:0], 14'd0};
            3'd3:    len_group = {data_byte[6:0], 21'd0};
            default: len_group = '0;
        endcase
    end

    always_comb
    begin
        state_next = state;
        rc         = 8'd0;
        rc_valid   = 1'b0;
        err        = 1'b0;
        unique case (state.phase)
            PH_LENGTH:
            begin
                if (state.len_cnt >= MaxLenBytes)
                begin
                    err              = 1'b1;
                    state_next.phase = PH_DRAIN;
                end
                else
                begin
                    state_next.len_acc = state.len_acc + len_group;
                    state_next.len_cnt = state.len_cnt + 3'd1;
                    if ((data_byte & ContBit) == 8'd0)
                    begin
                        state_next.phase = PH_ID_HI;
                    end
                end
            end
            PH_ID_HI:
            begin
                state_next.pkt_id = {data_byte, 8'd0};
                state_next.phase  = PH_ID_LO;
            end
            PH_ID_LO:
            begin
                state_next.pkt_id = {state.pkt_id[15:8], data_byte};
                state_next.phase  = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                rc       = data_byte;
                rc_valid = 1'b1;
            end
            PH_DRAIN:
            begin
                err = 1'b1;
            end
            default:
            begin
                state_next.header  = data_byte;
                state_next.len_acc = '0;
                state_next.len_cnt = '0;
                state_next.pkt_id  = '0;
                state_next.phase   = PH_LENGTH;
            end
        endcase

        if (final_byte)
        begin
            state_next.phase = PH_HEADER;
        end

        result.header_byte       = state_next.header;
        result.remaining_length  = state_next.len_acc;
        result.packet_id         = state_next.pkt_id;
        result.return_code       = rc;
        result.return_code_valid = rc_valid;
        result.length_error      = err;
        result.message_end       = final_byte;
    end

endmodule

// ===== hw/rtl/mqtt_suback_byte_parser.sv =====
// SUBACK byte parser: takes one message byte per beat and returns one result per
// byte, one byte per cycle sustained with each result registered; the parse state
// update and the result register form a single stage, so back-to-back beats
// flow while out_ready is high and the input stalls only while a result waits.
// The result shows the stored fixed header, the remaining length decoded so
// far, the packet id so far, the byte itself when it is a return code, an error
// from a fifth length byte up to message end, and message_end on the final byte.
module mqtt_suback_byte_parser
    import msub_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                final_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          header_byte,
    output logic [LenWidth-1:0] remaining_length,
    output logic [IdWidth-1:0]  packet_id,
    output logic [7:0]          return_code,
    output logic                return_code_valid,
    output logic                length_error,
    output logic                message_end
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result_reg;
    parse_result_t result_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    msub_step u_step (
        .state      (state_reg),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .state_next (state_next),
        .result     (result_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_HEADER, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    // hold the result until the beat is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign header_byte       = result_reg.header_byte;
    assign remaining_length  = result_reg.remaining_length;
    assign packet_id         = result_reg.packet_id;
    assign return_code       = result_reg.return_code;
    assign return_code_valid = result_reg.return_code_valid;
    assign length_error      = result_reg.length_error;
    assign message_end       = result_reg.message_end;

    a_final_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> state_reg.phase == PH_HEADER)
        else $error("final byte did not return parser to header phase");

    a_rc_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.return_code_valid && result_reg.length_error))
        else $error("return code and length error flagged on same byte");

    a_len_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.len_cnt <= MaxLenBytes)
        else $error("length byte count beyond four");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(result_reg))
        else $error("stalled result changed");

endmodule
